### design/urc_pkg.sv
// Package for the ultrasonic range controller.
// Holds the beat structs, phase and status codes and register indexes; no dependencies.
`default_nettype none

package urc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned TicksW  = 16;
  localparam int unsigned ScaleW  = 10;
  localparam int unsigned DistW   = 12;
  localparam int unsigned CountW  = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // Register reset values
  localparam logic [TicksW-1:0] TriggerTicksRst    = 16'd1;
  localparam logic [TicksW-1:0] TimeoutTicksRst    = 16'd100;
  localparam logic [ScaleW-1:0] RoundTripScaleRst  = 10'd34;
  localparam logic [DistW-1:0]  DistanceLimitRst   = 12'd400;
  localparam logic [DistW-1:0]  ChangeThresholdRst = 12'd5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIGGER_TICKS    = 3'd0,
    REG_TIMEOUT_TICKS    = 3'd1,
    REG_ROUND_TRIP_SCALE = 3'd2,
    REG_DISTANCE_LIMIT   = 3'd3,
    REG_CHANGE_THRESHOLD = 3'd4
  } reg_idx_t;

  // Measurement phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_RANGE    = 2'd1,
    ST_START_TO = 2'd2,
    ST_END_TO   = 2'd3
  } status_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic             trigger_level;
    logic             busy_res;
    logic             done_res;
    logic [DistW-1:0] distance_cm;
    logic [1:0]       status;
    logic             changed;
  } out_item_t;

endpackage : urc_pkg

`default_nettype wire

### design/ultrasonic_range_controller.sv
// Top level of the ultrasonic range controller: tick input register, phase logic, result register.
// Depends on urc_pkg for beat structs, phase and status codes, register indexes.
`default_nettype none

// One input beat is one time tick carrying the start request and the sampled echo
// level; each tick yields exactly one result beat. A tick passes through an input
// register and one pass of phase logic into the result register, so the block takes
// one tick per clock, stalling only when the result register is full and not drained.
// The distance is the echo tick count times the round-trip scale, halved, from a single
// 17x10 multiply; timeouts and out-of-range readings report the last valid distance.
// Configuration writes are always accepted and take effect at once, so write registers
// only while no measurement is running.
module ultrasonic_range_controller
  import urc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_data
);

  localparam int unsigned ProdW = CountW + ScaleW;

  // Configuration registers
  logic [TicksW-1:0] trigger_ticks_r;
  logic [TicksW-1:0] timeout_ticks_r;
  logic [ScaleW-1:0] scale_r;
  logic [DistW-1:0]  limit_r;
  logic [DistW-1:0]  threshold_r;

  // Pipeline registers
  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  logic      advance;

  // Measurement state
  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [DistW-1:0]  last_valid_r, last_valid_nxt;
  logic [DistW-1:0]  last_rep_r, last_rep_nxt;
  out_item_t         res_nxt;

  // Datapath intermediates
  logic [CountW-1:0] cnt_inc;
  logic [CountW-1:0] trig_cnt;
  logic              fin;
  status_t           fin_st;
  logic [ProdW-1:0]  product;
  logic [ProdW-2:0]  raw;
  logic              raw_ok;
  logic [DistW-1:0]  rep_dist;
  logic [DistW-1:0]  diff;
  logic              chg;
  status_t           rep_st;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TriggerTicksRst;
      timeout_ticks_r <= TimeoutTicksRst;
      scale_r         <= RoundTripScaleRst;
      limit_r         <= DistanceLimitRst;
      threshold_r     <= ChangeThresholdRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRIGGER_TICKS:    trigger_ticks_r <= cfg_data;
        REG_TIMEOUT_TICKS:    timeout_ticks_r <= cfg_data;
        REG_ROUND_TRIP_SCALE: scale_r         <= cfg_data[ScaleW-1:0];
        REG_DISTANCE_LIMIT:   limit_r         <= cfg_data[DistW-1:0];
        REG_CHANGE_THRESHOLD: threshold_r     <= cfg_data[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance a held tick when the result register can take it
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Distance arithmetic
  assign cnt_inc  = cnt_r + 1'b1;
  assign trig_cnt = (phase_r == PH_IDLE) ? CountW'(1) : cnt_inc;
  assign product  = ProdW'(cnt_r) * ProdW'(scale_r);
  assign raw      = product[ProdW-1:1];
  assign raw_ok   = (fin_st == ST_VALID) && (raw <= (ProdW-1)'(limit_r));
  assign rep_dist = raw_ok ? raw[DistW-1:0] : last_valid_r;
  assign diff     = (rep_dist >= last_rep_r) ? rep_dist - last_rep_r : last_rep_r - rep_dist;
  assign chg      = diff > threshold_r;
  assign rep_st   = (fin_st == ST_VALID && !raw_ok) ? ST_RANGE : fin_st;

  // Phase logic for one tick
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    fin            = 1'b0;
    fin_st         = ST_VALID;
    last_valid_nxt = last_valid_r;
    last_rep_nxt   = last_rep_r;
    res_nxt        = '0;

    case (phase_r)
      PH_IDLE, PH_TRIG: begin
        if (phase_r == PH_TRIG || in_r.start_req) begin
          res_nxt.trigger_level = 1'b1;
          if (trig_cnt >= CountW'(trigger_ticks_r)) begin
            phase_nxt = PH_RISE;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_TRIG;
            cnt_nxt   = trig_cnt;
          end
        end
      end
      PH_RISE: begin
        if (in_r.echo_level) begin
          phase_nxt = PH_HIGH;
          cnt_nxt   = CountW'(1);
          if (CountW'(1) > CountW'(timeout_ticks_r)) begin
            fin    = 1'b1;
            fin_st = ST_END_TO;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > CountW'(timeout_ticks_r)) begin
            fin    = 1'b1;
            fin_st = ST_START_TO;
          end
        end
      end
      PH_HIGH: begin
        if (!in_r.echo_level) begin
          fin    = 1'b1;
          fin_st = ST_VALID;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > CountW'(timeout_ticks_r)) begin
            fin    = 1'b1;
            fin_st = ST_END_TO;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase

    // Finish: report distance, hold last valid, track last reported
    if (fin) begin
      phase_nxt            = PH_IDLE;
      cnt_nxt              = '0;
      res_nxt.done_res     = 1'b1;
      res_nxt.distance_cm  = rep_dist;
      res_nxt.status       = rep_st;
      res_nxt.changed      = chg;
      if (raw_ok) begin
        last_valid_nxt = raw[DistW-1:0];
      end
      if (chg) begin
        last_rep_nxt = rep_dist;
      end
    end

    res_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Result register and measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
      last_valid_r <= '0;
      last_rep_r   <= '0;
    end else begin
      if (advance) begin
        out_vld_r    <= 1'b1;
        phase_r      <= phase_nxt;
        cnt_r        <= cnt_nxt;
        last_valid_r <= last_valid_nxt;
        last_rep_r   <= last_rep_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register not one-hot");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.done_res |-> !out_r.busy_res && !out_r.trigger_level)
    else $error("finished measurement flagged busy or triggering");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.done_res |->
      out_r.distance_cm == '0 && out_r.status == ST_VALID && !out_r.changed)
    else $error("report fields set without a finished measurement");

  a_report_is_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.done_res |-> out_r.distance_cm == last_valid_r)
    else $error("reported distance differs from held valid distance");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_r.busy_res == (phase_r != PH_IDLE))
    else $error("busy flag does not match phase");

endmodule : ultrasonic_range_controller

`default_nettype wire
